// ===== sv/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the double-ended queue ring store.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 7;
    localparam int REQ_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int CAPACITY_DEF  = 64;

    // request codes; the two unused codes behave as a count
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_COUNT     = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic s_ready;
        logic out_load;
        logic rd_issue;
        logic dump_emit;
    } t_ctrl;

endpackage

// ===== sv/circular_deque_store_core.sv =====
// ----------------------------------------------------------------------------
// circular_deque_store_core
// Bounded double-ended queue of 32-bit words kept in a single ring memory.
// ----------------------------------------------------------------------------
// Insert, remove and count: one word in, one result in the output register
//   on the next cycle; a new request is taken every cycle while results drain.
// Dump of N entries: each entry passes through the registered memory read and
//   then the output register, one per cycle while the output is taken; input
//   is held off until the last one is loaded.
// Reset clears head, occupancy and handshake state; memory contents are kept.
// ----------------------------------------------------------------------------
module circular_deque_store_core #(
    parameter int CAPACITY = cdq_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] in_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] req_type

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] out_value, [38:32] entry_count, [39] zero
    output logic [2:0]  m_axis_tuser,   // [0] item_valid, [2:1] status
    output logic        m_axis_tlast    // last_of_run
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // ring memory
    logic [cdq_pkg::DATA_W-1:0] mem [CAPACITY];

    cdq_pkg::t_state r_state, n_state;
    cdq_pkg::t_ctrl  ctrl;

    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_occ;

    logic [CNT_W-1:0]           r_rd_idx;
    logic                       r_rd_vld;
    logic                       r_rd_last;
    logic [cdq_pkg::DATA_W-1:0] r_rd_data;

    logic                          r_out_valid;
    logic [cdq_pkg::DATA_W-1:0]    r_out_value;
    logic [cdq_pkg::COUNT_W-1:0]   r_out_count;
    logic                          r_out_item;
    logic [cdq_pkg::STATUS_W-1:0]  r_out_status;
    logic                          r_out_last;

    logic                      accept;
    logic [cdq_pkg::REQ_W-1:0] req;
    logic                      full;
    logic                      empty;
    logic [IDX_W-1:0]          head_dec;
    logic [IDX_W-1:0]          head_inc;
    logic [IDX_W-1:0]          tail_pos;
    logic [IDX_W-1:0]          rd_addr;
    logic [CNT_W-1:0]          rd_idx_inc;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;

    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY)) begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign req        = s_axis_tuser;
    assign accept     = s_axis_tvalid && ctrl.s_ready;
    assign full       = (r_occ == CNT_W'(CAPACITY));
    assign empty      = (r_occ == '0);
    assign head_dec   = (r_head == '0) ? IDX_W'(CAPACITY - 1) : r_head - IDX_W'(1);
    assign head_inc   = ring_pos(r_head, IDX_W'(1));
    assign tail_pos   = ring_pos(r_head, r_occ[IDX_W-1:0]);
    assign rd_addr    = ring_pos(r_head, r_rd_idx[IDX_W-1:0]);
    assign rd_idx_inc = r_rd_idx + CNT_W'(1);

    assign wr_en   = accept && !full &&
                     (req == cdq_pkg::REQ_INS_FRONT || req == cdq_pkg::REQ_INS_BACK);
    assign wr_addr = (req == cdq_pkg::REQ_INS_FRONT) ? head_dec : tail_pos;

    // control outputs of the sequencer
    always_comb begin
        ctrl.out_load  = !r_out_valid || m_axis_tready;
        ctrl.s_ready   = 1'b0;
        ctrl.rd_issue  = 1'b0;
        ctrl.dump_emit = 1'b0;
        unique case (r_state)
            cdq_pkg::ST_IDLE: begin
                ctrl.s_ready = ctrl.out_load;
            end
            cdq_pkg::ST_DUMP: begin
                ctrl.dump_emit = r_rd_vld && ctrl.out_load;
                // refill the read stage whenever it is empty or being drained
                ctrl.rd_issue  = (r_rd_idx < r_occ) && (!r_rd_vld || ctrl.out_load);
            end
            default: begin
                ctrl.s_ready = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdq_pkg::ST_IDLE: begin
                if (accept && req == cdq_pkg::REQ_DUMP && !empty) begin
                    n_state = cdq_pkg::ST_DUMP;
                end
            end
            cdq_pkg::ST_DUMP: begin
                if (ctrl.dump_emit && r_rd_last) begin
                    n_state = cdq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    // memory port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_axis_tdata;
        end
        if (ctrl.rd_issue) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdq_pkg::ST_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (accept) begin
                unique case (req) inside
                    cdq_pkg::REQ_INS_FRONT: begin
                        if (!full) begin
                            r_head <= head_dec;
                            r_occ  <= r_occ + CNT_W'(1);
                        end
                    end
                    cdq_pkg::REQ_INS_BACK: begin
                        if (!full) begin
                            r_occ <= r_occ + CNT_W'(1);
                        end
                    end
                    cdq_pkg::REQ_REM_FRONT: begin
                        if (!empty) begin
                            r_head <= head_inc;
                            r_occ  <= r_occ - CNT_W'(1);
                        end
                    end
                    cdq_pkg::REQ_REM_BACK: begin
                        if (!empty) begin
                            r_occ <= r_occ - CNT_W'(1);
                        end
                    end
                    default: begin
                        r_occ <= r_occ;
                    end
                endcase
                r_rd_idx <= '0;
                r_rd_vld <= 1'b0;
            end else if (r_state == cdq_pkg::ST_DUMP) begin
                if (ctrl.rd_issue) begin
                    r_rd_idx  <= rd_idx_inc;
                    r_rd_vld  <= 1'b1;
                    r_rd_last <= (rd_idx_inc == r_occ);
                end else if (ctrl.dump_emit) begin
                    r_rd_vld <= 1'b0;
                end
            end

            // output register: a dump request on a non-empty store loads nothing here
            if (accept) begin
                r_out_valid <= !(req == cdq_pkg::REQ_DUMP && !empty);
            end else if (ctrl.dump_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value <= '0;
            r_out_item  <= 1'b0;
            r_out_last  <= 1'b1;
            case (req) inside
                cdq_pkg::REQ_INS_FRONT, cdq_pkg::REQ_INS_BACK: begin
                    r_out_status <= full ? cdq_pkg::STAT_FULL : cdq_pkg::STAT_OK;
                    r_out_count  <= cdq_pkg::COUNT_W'(full ? r_occ : r_occ + CNT_W'(1));
                end
                cdq_pkg::REQ_REM_FRONT, cdq_pkg::REQ_REM_BACK: begin
                    r_out_status <= empty ? cdq_pkg::STAT_EMPTY : cdq_pkg::STAT_OK;
                    r_out_count  <= cdq_pkg::COUNT_W'(empty ? r_occ : r_occ - CNT_W'(1));
                end
                cdq_pkg::REQ_DUMP: begin
                    r_out_status <= cdq_pkg::STAT_EMPTY;
                    r_out_count  <= cdq_pkg::COUNT_W'(r_occ);
                end
                default: begin
                    r_out_status <= cdq_pkg::STAT_OK;
                    r_out_count  <= cdq_pkg::COUNT_W'(r_occ);
                end
            endcase
        end else if (ctrl.dump_emit) begin
            r_out_value  <= r_rd_data;
            r_out_item   <= 1'b1;
            r_out_last   <= r_rd_last;
            r_out_status <= cdq_pkg::STAT_OK;
            r_out_count  <= cdq_pkg::COUNT_W'(r_occ);
        end
    end

    assign s_axis_tready = ctrl.s_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_value};
    assign m_axis_tuser  = {r_out_status, r_out_item};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== sim/tb_circular_deque_store_core.sv =====
// ----------------------------------------------------------------------------
// tb_circular_deque_store_core
// Self-checking bench for the bounded double-ended queue ring store.
// ----------------------------------------------------------------------------
// The bench drives requests on the slave stream and keeps its own copy of the
// ring: front position, fill level and stored words. Each accepted request is
// turned into the results it should cause, and each result word on the master
// stream is checked against the oldest one still owed. The run covers the
// empty-store corner cases, the unused request codes, extreme values, a full
// store with refused inserts under a long output back-pressure, and random
// traffic that swings between filling and draining.
// ----------------------------------------------------------------------------
module tb_circular_deque_store_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = cdq_pkg::CAPACITY_DEF;
    localparam int LONG_HOLD   = 150;
    localparam int DRAIN_WAIT  = 8;
    localparam int DRAIN_COUNT = 24;
    localparam int RANDOM_REQS = 60;

    // unused codes; the block treats them as a count
    localparam logic [cdq_pkg::REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [cdq_pkg::REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                         pad;
        logic [cdq_pkg::COUNT_W-1:0]  count;
        logic [cdq_pkg::DATA_W-1:0]   value;
        logic [cdq_pkg::STATUS_W-1:0] status;
        logic                         item_valid;
        logic                         last;
    } t_deque_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] in_value
    logic [2:0]  s_axis_tuser;   // [2:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] out_value, [38:32] entry_count, [39] zero
    logic [2:0]  m_axis_tuser;   // [0] item_valid, [2:1] status
    logic        m_axis_tlast;

    // bench copy of the ring store
    logic [cdq_pkg::DATA_W-1:0] ring_copy [CAPACITY];
    int                         front_pos;
    int                         fill_level;

    t_deque_result due_results [$];

    bit calm_phase;
    bit sink_hold_req;
    int error_count;
    int words_sent;
    int results_checked;
    int full_refusals;
    int empty_hits;

    circular_deque_store_core #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void owe_result(input logic [cdq_pkg::DATA_W-1:0]   value,
                                       input logic                         item_valid,
                                       input logic [cdq_pkg::STATUS_W-1:0] status,
                                       input logic                         last);
        t_deque_result res;
        res.pad        = 1'b0;
        res.count      = fill_level[cdq_pkg::COUNT_W-1:0];
        res.value      = value;
        res.status     = status;
        res.item_valid = item_valid;
        res.last       = last;
        due_results.push_back(res);
    endfunction

    // Apply one request to the bench ring and queue the results it causes.
    function automatic void predict_request(input logic [cdq_pkg::REQ_W-1:0]  req,
                                            input logic [cdq_pkg::DATA_W-1:0] val);
        case (req) inside
            cdq_pkg::REQ_INS_FRONT, cdq_pkg::REQ_INS_BACK: begin
                if (fill_level >= CAPACITY) begin
                    full_refusals++;
                    owe_result('0, 1'b0, cdq_pkg::STAT_FULL, 1'b1);
                end else begin
                    if (req == cdq_pkg::REQ_INS_FRONT) begin
                        front_pos = (front_pos + CAPACITY - 1) % CAPACITY;
                        ring_copy[front_pos] = val;
                    end else begin
                        ring_copy[(front_pos + fill_level) % CAPACITY] = val;
                    end
                    fill_level++;
                    owe_result('0, 1'b0, cdq_pkg::STAT_OK, 1'b1);
                end
            end
            cdq_pkg::REQ_REM_FRONT, cdq_pkg::REQ_REM_BACK: begin
                if (fill_level == 0) begin
                    empty_hits++;
                    owe_result('0, 1'b0, cdq_pkg::STAT_EMPTY, 1'b1);
                end else begin
                    if (req == cdq_pkg::REQ_REM_FRONT)
                        front_pos = (front_pos + 1) % CAPACITY;
                    fill_level--;
                    owe_result('0, 1'b0, cdq_pkg::STAT_OK, 1'b1);
                end
            end
            cdq_pkg::REQ_DUMP: begin
                if (fill_level == 0) begin
                    empty_hits++;
                    owe_result('0, 1'b0, cdq_pkg::STAT_EMPTY, 1'b1);
                end else begin
                    for (int k = 0; k < fill_level; k++)
                        owe_result(ring_copy[(front_pos + k) % CAPACITY], 1'b1,
                                   cdq_pkg::STAT_OK, k == fill_level - 1);
                end
            end
            default: begin
                owe_result('0, 1'b0, cdq_pkg::STAT_OK, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [cdq_pkg::DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       random_word = 32'h8000_0000;
            1:       random_word = 32'h7FFF_FFFF;
            2:       random_word = 32'hFFFF_FFFF;
            default: random_word = $urandom;
        endcase
    endfunction

    // Offer one word; return once it has been taken.
    task automatic send_word(input logic [cdq_pkg::REQ_W-1:0]  req,
                             input logic [cdq_pkg::DATA_W-1:0] val);
        int gap;
        @(negedge i_clk);
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_request(req, val);
        words_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic test_empty_store();
        send_word(cdq_pkg::REQ_COUNT, random_word());
        send_word(cdq_pkg::REQ_REM_FRONT, random_word());
        send_word(cdq_pkg::REQ_REM_BACK, random_word());
        send_word(cdq_pkg::REQ_DUMP, random_word());
        send_word(REQ_SPARE_6, random_word());
        send_word(REQ_SPARE_7, random_word());
    endtask

    task automatic test_extreme_values();
        send_word(cdq_pkg::REQ_INS_BACK, 32'h7FFF_FFFF);
        send_word(cdq_pkg::REQ_INS_FRONT, 32'h8000_0000);
        send_word(cdq_pkg::REQ_INS_BACK, 32'h0000_0000);
        send_word(cdq_pkg::REQ_INS_FRONT, 32'hFFFF_FFFF);
        send_word(cdq_pkg::REQ_INS_BACK, 32'h0000_0001);
        send_word(cdq_pkg::REQ_DUMP, 32'h0);
        send_word(cdq_pkg::REQ_COUNT, 32'h0);
        send_word(cdq_pkg::REQ_REM_FRONT, 32'h0);
        send_word(cdq_pkg::REQ_REM_BACK, 32'h0);
        send_word(cdq_pkg::REQ_DUMP, 32'h0);
        repeat (3) send_word(cdq_pkg::REQ_REM_FRONT, 32'h0);
        send_word(cdq_pkg::REQ_REM_BACK, 32'h0);
    endtask

    // Fill the store while the sink holds off, so the block backs up and
    // stalls its input; then hit both full-insert refusals and drain part of it.
    task automatic test_full_store();
        sink_hold_req = 1'b1;
        for (int i = 0; i < CAPACITY; i++)
            send_word((i % 3 == 0) ? cdq_pkg::REQ_INS_FRONT : cdq_pkg::REQ_INS_BACK,
                      random_word());
        send_word(cdq_pkg::REQ_INS_FRONT, random_word());
        send_word(cdq_pkg::REQ_INS_BACK, random_word());
        send_word(cdq_pkg::REQ_COUNT, 32'h0);
        send_word(cdq_pkg::REQ_DUMP, 32'h0);
        repeat (DRAIN_COUNT)
            send_word($urandom_range(0, 1) ? cdq_pkg::REQ_REM_FRONT : cdq_pkg::REQ_REM_BACK,
                      32'h0);
    endtask

    // Swing between filling and draining spells so both ends of the store get hit.
    task automatic test_random_traffic(input int n_items);
        int                        pick;
        int                        ins_share;
        logic [cdq_pkg::REQ_W-1:0] req;
        for (int i = 0; i < n_items; i++) begin
            if (i % 30 == 0)
                ins_share = $urandom_range(0, 1) ? 62 : 28;
            if (i == n_items - 30)
                calm_phase = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
                req = cdq_pkg::REQ_DUMP;
            end else if (pick < 12) begin
                case ($urandom_range(0, 2))
                    0:       req = REQ_SPARE_6;
                    1:       req = REQ_SPARE_7;
                    default: req = cdq_pkg::REQ_COUNT;
                endcase
            end else if (pick < 12 + ins_share) begin
                req = $urandom_range(0, 1) ? cdq_pkg::REQ_INS_FRONT : cdq_pkg::REQ_INS_BACK;
            end else begin
                req = $urandom_range(0, 1) ? cdq_pkg::REQ_REM_FRONT : cdq_pkg::REQ_REM_BACK;
            end
            send_word(req, random_word());
        end
    endtask

    // Sink side: random short stalls, one long hold on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_deque_result got;
        t_deque_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pad        = m_axis_tdata[39];
            got.count      = m_axis_tdata[38:32];
            got.value      = m_axis_tdata[31:0];
            got.status     = m_axis_tuser[2:1];
            got.item_valid = m_axis_tuser[0];
            got.last       = m_axis_tlast;
            if (due_results.size() == 0) begin
                error_count++;
                $display("%0t: result word with nothing owed: value=%h count=%0d status=%0d",
                         $realtime, got.value, got.count, got.status);
            end else begin
                want = due_results.pop_front();
                results_checked++;
                if (got !== want) begin
                    error_count++;
                    $display({"%0t: mismatch, expected value=%h valid=%b count=%0d",
                              " status=%0d last=%b pad=%b"},
                             $realtime, want.value, want.item_valid, want.count,
                             want.status, want.last, want.pad);
                    $display({"%0t:           actual   value=%h valid=%b count=%0d",
                              " status=%0d last=%b pad=%b"},
                             $realtime, got.value, got.item_valid, got.count,
                             got.status, got.last, got.pad);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("%0t: run timed out, %0d results still owed", $realtime, due_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        calm_phase    = 1'b0;
        sink_hold_req = 1'b0;
        front_pos     = 0;
        fill_level    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_store();
        test_extreme_values();
        test_full_store();
        test_random_traffic(RANDOM_REQS);
        stop_sending();

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d result words.", words_sent, results_checked);
        $display("Saw %0d refused inserts on a full store and %0d empty-store replies.",
                 full_refusals, empty_hits);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
